@@ rtl/core/assert_macros.svh @@
// Assertion helpers included by the table unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  `ASSERT_ALWAYS(lbl, clk, rst, !(cond))

`endif

@@ rtl/core/tet_pkg.sv @@
`default_nettype none

package tet_pkg;

  // Field widths
  localparam int KEY_W  = 32;
  localparam int TIME_W = 31;
  localparam int EXP_W  = 32;
  localparam int CNT_W  = 7;
  localparam int CNT_MAX = 127;

  // Action codes
  localparam logic [1:0] ACT_GENERATE = 2'd0;
  localparam logic [1:0] ACT_RENEW    = 2'd1;

  // One table slot as stored in the memory
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [EXP_W-1:0] expiry;
  } tet_entry_t;

  localparam int ENTRY_W = $bits(tet_entry_t);

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } tet_state_t;

endpackage

`default_nettype wire

@@ rtl/core/tet_ram.sv @@
`default_nettype none

module tet_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/token_expiry_table_unit.sv @@
// Flow: an accepted word is latched, every slot of the memory is read and
// folded into a scan summary, and the write-back loads the result register.
// No new word is taken until that write-back, which waits until the result
// register is free; the single read port scans the memory one slot a cycle.
// Reset: synchronous; a clearing pass writes every slot invalid while
// s_axis_tready stays low. lifetime resets to 5.
`default_nettype none

module token_expiry_table_unit import tet_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // lifetime register
  input  wire logic        cfg_we,
  input  wire logic [30:0] cfg_wdata,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // [31:0] token_key, [62:32] current_time
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] action
  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [6:0] unexpired_count
  output logic [1:0]       m_axis_tuser   // [0] table_full, [1] renewed
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

  tet_state_t state, state_next;

  logic [TIME_W-1:0] lifetime;

  // latched input word
  logic [1:0]        act;
  logic [KEY_W-1:0]  key;
  logic [TIME_W-1:0] now;

  // scan bookkeeping
  logic [AW-1:0] clr_idx;
  logic [AW-1:0] issue_idx;
  logic          rd_pend;
  logic [AW-1:0] rd_idx;
  logic          found_match;
  logic [AW-1:0] match_idx;
  logic          match_live;
  logic          found_free;
  logic [AW-1:0] free_idx;
  logic [CW-1:0] live_cnt;

  // output register
  logic             out_valid;
  logic [CNT_W-1:0] out_cnt;
  logic             out_full;
  logic             out_renewed;

  // memory ports
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  tet_entry_t          rd_entry;
  tet_entry_t          new_entry;

  // shared compare unit and write-back decision
  logic             in_acc;
  logic             out_free;
  logic             write_go;
  logic             e_live;
  logic             e_match;
  logic [EXP_W-1:0] new_expiry;
  logic             do_write;
  logic [AW-1:0]    wb_idx;
  logic             old_live;
  logic             new_live;
  logic             wb_full;
  logic             wb_renewed;
  logic [CW:0]      cnt_after;
  logic [CNT_W-1:0] cnt_sat;

  tet_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (issue_idx),
    .rdata (ram_rdata)
  );

  assign rd_entry = ram_rdata;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;

  // Compare one slot per cycle against the latched key and time
  assign e_live  = rd_entry.valid && (rd_entry.expiry > {1'b0, now});
  assign e_match = rd_entry.valid && (rd_entry.key == key);

  // Decide the write-back from the scan summary
  assign new_expiry = {1'b0, now} + {1'b0, lifetime};
  assign new_live   = (lifetime != '0);

  always_comb begin
    do_write   = 1'b0;
    wb_idx     = match_idx;
    old_live   = 1'b0;
    wb_full    = 1'b0;
    wb_renewed = 1'b0;
    priority if (act == ACT_GENERATE) begin
      if (found_match) begin
        do_write = 1'b1;
        old_live = match_live;
      end else if (found_free) begin
        do_write = 1'b1;
        wb_idx   = free_idx;
      end else begin
        wb_full  = 1'b1;
      end
    end else if (act == ACT_RENEW) begin
      if (found_match && match_live) begin
        do_write   = 1'b1;
        old_live   = 1'b1;
        wb_renewed = 1'b1;
      end
    end else begin
      do_write = 1'b0;
    end
  end

  assign cnt_after = {1'b0, live_cnt} - (CW+1)'(old_live)
                   + (CW+1)'(do_write && new_live);
  assign cnt_sat   = (32'(cnt_after) > 32'(CNT_MAX)) ? CNT_W'(CNT_MAX)
                                                     : CNT_W'(cnt_after);

  assign new_entry.valid  = 1'b1;
  assign new_entry.key    = key;
  assign new_entry.expiry = new_expiry;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_idx == LAST_IDX) state_next = ST_IDLE;
      ST_IDLE:  if (in_acc) state_next = ST_SCAN;
      ST_SCAN:  if (issue_idx == LAST_IDX) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_WRITE;
      ST_WRITE: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    write_go      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = clr_idx;
    ram_wdata     = '0;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_WRITE: begin
        write_go  = out_free;
        ram_we    = out_free && do_write;
        ram_waddr = wb_idx;
        ram_wdata = new_entry;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // State and lifetime register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      lifetime <= TIME_W'(5);
    end else begin
      state <= state_next;
      if (cfg_we) begin
        lifetime <= cfg_wdata;
      end
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= clr_idx + AW'(1);
    end
  end

  // Latch the input word and run the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend     <= 1'b0;
      issue_idx   <= '0;
      found_match <= 1'b0;
      found_free  <= 1'b0;
      live_cnt    <= '0;
    end else begin
      rd_pend <= (state == ST_SCAN);
      rd_idx  <= issue_idx;
      if (in_acc) begin
        act         <= s_axis_tuser;
        key         <= s_axis_tdata[31:0];
        now         <= s_axis_tdata[62:32];
        issue_idx   <= '0;
        found_match <= 1'b0;
        found_free  <= 1'b0;
        live_cnt    <= '0;
      end else if (state == ST_SCAN) begin
        issue_idx <= issue_idx + AW'(1);
      end
      // fold the slot read last cycle into the summary
      if (rd_pend) begin
        if (e_match && !found_match) begin
          found_match <= 1'b1;
          match_idx   <= rd_idx;
          match_live  <= e_live;
        end
        if (!e_live && !found_free) begin
          found_free <= 1'b1;
          free_idx   <= rd_idx;
        end
        if (e_live) begin
          live_cnt <= live_cnt + CW'(1);
        end
      end
    end
  end

  // Result register: load on write-back, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (write_go) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (write_go) begin
      out_cnt     <= cnt_sat;
      out_full    <= wb_full;
      out_renewed <= wb_renewed;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_cnt};
  assign m_axis_tuser  = {out_renewed, out_full};

  // Checks
  `include "assert_macros.svh"

  `ASSERT_NEVER(a_flags_excl, clk, rst, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1])
  `ASSERT_ALWAYS(a_accept_scan, clk, rst, in_acc |=> (state == ST_SCAN))
  `ASSERT_ALWAYS(a_we_state, clk, rst, ram_we |-> (state == ST_CLEAR || state == ST_WRITE))
  `ASSERT_ALWAYS(a_cnt_bound, clk, rst, m_axis_tvalid |-> (32'(out_cnt) <= TABLE_ENTRIES))

endmodule

`default_nettype wire

@@ tb/tb_token_expiry_table_unit.sv @@
`default_nettype none

module tb_token_expiry_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tet_pkg::*;

  localparam int TABLE_ENTRIES = 64;
  localparam int NUM_PHASES = 4;

  // Count-only actions; both spare codes leave the table alone
  localparam logic [1:0] ACT_COUNT     = 2'd2;
  localparam logic [1:0] ACT_COUNT_ALT = 2'd3;

  localparam logic [30:0] TIME_MAX = 31'h7FFF_FFFF;
  localparam logic [31:0] KEY_POOL_BASE = 32'hA000_0000;
  localparam int KEY_POOL_SIZE = 80;

  // One result word as the block reports it
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic             renewed;
  } tally_t;

  // One directed input word, with a typed-in result where it is obvious
  typedef struct {
    logic [1:0]        act;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    bit                typed;
    tally_t            want;
  } token_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [30:0]       cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata = '0;  // [31:0] token_key, [62:32] current_time
  logic [1:0]        s_axis_tuser = '0;  // [1:0] action
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;       // [6:0] unexpired_count
  logic [1:0]        m_axis_tuser;       // [0] table_full, [1] renewed

  // Shadow copy of the token table and its lifetime register
  logic              tbl_valid  [TABLE_ENTRIES];
  logic [KEY_W-1:0]  tbl_key    [TABLE_ENTRIES];
  logic [EXP_W-1:0]  tbl_expiry [TABLE_ENTRIES];
  logic [30:0]       life_ticks = 31'd5;

  tally_t            pending_tallies[$];
  int                mismatches = 0;
  int                results_seen = 0;
  int                snd_idle_pct = 0;
  int                rcv_idle_pct = 0;

  token_expiry_table_unit #(.TABLE_ENTRIES(TABLE_ENTRIES)) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  // Apply one action to the shadow table and return the tally it yields
  function automatic tally_t table_apply(input logic [1:0] act, input logic [KEY_W-1:0] key,
                                         input logic [TIME_W-1:0] now);
    int     hit;
    int     live;
    logic [EXP_W-1:0] new_exp;
    tally_t t;
    hit = -1;
    live = 0;
    t = '0;
    new_exp = {1'b0, now} + {1'b0, life_ticks};
    if (act == ACT_GENERATE || act == ACT_RENEW) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (hit < 0 && tbl_valid[i] && tbl_key[i] == key) hit = i;
      end
    end
    if (act == ACT_GENERATE) begin
      // take the lowest free or expired slot when the key is not held
      if (hit < 0) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (hit < 0 && !(tbl_valid[i] && tbl_expiry[i] > {1'b0, now})) hit = i;
        end
      end
      if (hit < 0) begin
        t.full = 1'b1;
      end else begin
        tbl_valid[hit] = 1'b1;
        tbl_key[hit] = key;
        tbl_expiry[hit] = new_exp;
      end
    end else if (act == ACT_RENEW) begin
      if (hit >= 0 && tbl_expiry[hit] > {1'b0, now}) begin
        tbl_expiry[hit] = new_exp;
        t.renewed = 1'b1;
      end
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_expiry[i] > {1'b0, now} && live < CNT_MAX) live++;
    end
    t.count = live[CNT_W-1:0];
    return t;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d, %s: got %0d, want %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // Present one word, hold it until accepted, and queue its tally
  task automatic push_token(input logic [1:0] act, input logic [KEY_W-1:0] key,
                            input logic [TIME_W-1:0] now, input bit typed, input tally_t want);
    tally_t predicted;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, now, key};
    s_axis_tuser <= act;
    do @(posedge clk); while (!s_axis_tready);
    predicted = table_apply(act, key, now);
    pending_tallies.insert(pending_tallies.size(), typed ? want : predicted);
    @(negedge clk);
  endtask

  // Stop sending and wait until every tally has come back
  task automatic drain_tallies();
    s_axis_tvalid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Receiver: stall at random, check each word against the oldest tally
  always @(negedge clk) begin
    m_axis_tready <= (rcv_idle_pct == 0) || ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  always @(posedge clk) begin : check_results
    tally_t head;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_tallies.size() == 0) begin
        report_mismatch("word with no tally pending", m_axis_tdata[6:0], -1);
      end else begin
        head = pending_tallies.pop_front();
        if (m_axis_tdata[6:0] !== head.count)
          report_mismatch("unexpired_count", m_axis_tdata[6:0], head.count);
        if (m_axis_tuser[0] !== head.full)
          report_mismatch("table_full", m_axis_tuser[0], head.full);
        if (m_axis_tuser[1] !== head.renewed)
          report_mismatch("renewed", m_axis_tuser[1], head.renewed);
      end
      results_seen++;
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    token_row_t  dir_rows[16];
    logic [30:0] phase_life[NUM_PHASES];
    int          phase_items[NUM_PHASES];
    logic [1:0]  act;
    logic [31:0] key;
    logic [31:0] t_next;
    logic [30:0] now;
    int          r;

    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_expiry[i] = '0;
    end
    phase_life = '{TIME_MAX, 31'd1, 31'd0, 31'd40};
    phase_items = '{220, 145, 145, 145};

    // Directed words under the reset lifetime of five ticks
    dir_rows = '{
      '{ACT_COUNT,     32'h0000_0000, 31'd0, 1'b1, '{7'd0, 1'b0, 1'b0}},
      '{ACT_RENEW,     32'hFFFF_FFFF, 31'd0, 1'b1, '{7'd0, 1'b0, 1'b0}},
      '{ACT_GENERATE,  32'h0000_0000, 31'd0, 1'b1, '{7'd1, 1'b0, 1'b0}},
      '{ACT_GENERATE,  32'hFFFF_FFFF, 31'd1, 1'b1, '{7'd2, 1'b0, 1'b0}},
      '{ACT_RENEW,     32'h0000_0000, 31'd4, 1'b1, '{7'd2, 1'b0, 1'b1}},
      '{ACT_COUNT_ALT, 32'hAAAA_AAAA, 31'd6, 1'b1, '{7'd1, 1'b0, 1'b0}},
      // renew of an expired key is refused
      '{ACT_RENEW,     32'hFFFF_FFFF, 31'd6, 1'b1, '{7'd1, 1'b0, 1'b0}},
      // generate of an expired key reuses its slot
      '{ACT_GENERATE,  32'hFFFF_FFFF, 31'd6, 1'b1, '{7'd2, 1'b0, 1'b0}},
      '{ACT_GENERATE,  32'h5555_5555, 31'd7, 1'b1, '{7'd3, 1'b0, 1'b0}},
      '{ACT_COUNT,     32'h0000_0000, TIME_MAX, 1'b1, '{7'd0, 1'b0, 1'b0}},
      // all slots expired: the lowest one is taken
      '{ACT_GENERATE,  32'h1234_5678, TIME_MAX, 1'b1, '{7'd1, 1'b0, 1'b0}},
      // time steps backward
      '{ACT_COUNT,     32'h0000_0000, 31'd3, 1'b1, '{7'd3, 1'b0, 1'b0}},
      '{ACT_RENEW,     32'h5555_5555, 31'd3, 1'b1, '{7'd3, 1'b0, 1'b1}},
      '{ACT_GENERATE,  32'h0000_0000, 31'd10, 1'b0, '0},
      '{ACT_RENEW,     32'h1234_5678, 31'd10, 1'b0, '0},
      '{ACT_GENERATE,  32'h5A5A_5A5A, 31'd2, 1'b0, '0}
    };

    // Hold reset, then release it
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    snd_idle_pct = 6;
    rcv_idle_pct = 62;
    foreach (dir_rows[i])
      push_token(dir_rows[i].act, dir_rows[i].key, dir_rows[i].now,
                 dir_rows[i].typed, dir_rows[i].want);
    now = 31'd20;

    // Random phases, each under its own lifetime, with an idling mix set per phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_tallies();
      cfg_we <= 1'b1;
      cfg_wdata <= phase_life[p];
      @(negedge clk);
      cfg_we <= 1'b0;
      life_ticks = phase_life[p];
      snd_idle_pct = (p == 0) ? 6 : (p == 1) ? 62 : 0;
      rcv_idle_pct = (p == 0) ? 62 : (p == 1) ? 6 : 0;

      for (int n = 0; n < phase_items[p]; n++) begin
        // advance time mostly in small steps, with rare jumps anywhere
        r = $urandom_range(0, 99);
        if (r < 60)      t_next = {1'b0, now} + $urandom_range(0, 2);
        else if (r < 90) t_next = {1'b0, now} + $urandom_range(0, 8);
        else if (r < 97) t_next = {1'b0, now} + $urandom_range(0, 64);
        else             t_next = $urandom_range(0, 32'h7FFF_FFFF);
        if (t_next > {1'b0, TIME_MAX}) t_next = $urandom_range(0, 1000);
        now = t_next[30:0];

        // draw keys mostly from a small pool so that they collide
        if ($urandom_range(0, 99) < 75) key = KEY_POOL_BASE + $urandom_range(0, KEY_POOL_SIZE - 1);
        else                            key = $urandom;

        r = $urandom_range(0, 99);
        if (r < 55)      act = ACT_GENERATE;
        else if (r < 80) act = ACT_RENEW;
        else if (r < 93) act = ACT_COUNT;
        else             act = ACT_COUNT_ALT;

        push_token(act, key, now, 1'b0, '0);
      end
    end

    // Drain and let the tail settle
    drain_tallies();
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
